// File: hw/rtl/mrd_pkg.sv
`default_nettype none

package mrd_pkg;

	localparam int RECORD_BYTES = 32;
	localparam int MAX_PAYLOAD  = 30;

	localparam int POS_W = $clog2(RECORD_BYTES);
	localparam int REM_W = $clog2(MAX_PAYLOAD + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_PORT_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_OFFSET = 2'd2;

	localparam logic [7:0] PORT_LOW_RST    = 8'd0;
	localparam logic [8:0] PORT_LIMIT_RST  = 9'd8;
	localparam logic [7:0] PORT_OFFSET_RST = 8'd0;

	typedef enum logic [1:0] {
		ST_PAYLOAD  = 2'd0,
		ST_PORT_ERR = 2'd1,
		ST_LEN_ERR  = 2'd2
	} status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mrd_if.sv
`default_nettype none

interface mrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_transfer;

	modport source (output valid, output data_byte, output end_of_transfer, input ready);
	modport sink   (input valid, input data_byte, input end_of_transfer, output ready);
endinterface

interface mrd_out_if;
	import mrd_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] port;
	logic [7:0] payload_byte;
	logic       record_last;
	status_t    status;

	modport source (output valid, output port, output payload_byte, output record_last,
		output status, input ready);
	modport sink   (input valid, input port, input payload_byte, input record_last,
		input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/multiport_record_deframer.sv
// Channel   Dir  Payload                                        Handshake
// din       in   data_byte[7:0], end_of_transfer                valid/ready
// dout      out  port[7:0], payload_byte[7:0], record_last,     valid/ready
//                status[1:0]
// cfg       in   cfg_index[1:0], cfg_data[8:0]                  cfg_we, no wait
//
// One byte per cycle sustained while dout does not stall the result register.
// Bytes pass an input register, then the header/length checks and counter update
// feed a result register in the same cycle.
// arst_n clears the parser state, both stage valids, and loads the register defaults.
// A stalled result register holds the input stage; din.ready drops only when both are full.
`default_nettype none

module multiport_record_deframer (
	input  wire                                clk,
	input  wire                                arst_n,
	mrd_in_if.sink                             din,
	mrd_out_if.source                          dout,
	input  wire                                cfg_we,
	input  wire [mrd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [mrd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mrd_pkg::*;

	logic [7:0] port_low_q;
	logic [8:0] port_limit_q;
	logic [7:0] tag_offset_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       cur_port_q;
	logic [REM_W-1:0] rem_q;
	logic             skip_q;

	logic       out_valid_q;
	logic [7:0] out_port_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	status_t    out_status_q;

	logic advance_s1;
	logic take_in;

	logic [POS_W-1:0] pos_d;
	logic [7:0]       cur_port_d;
	logic [REM_W-1:0] rem_d;
	logic             skip_d;
	logic             emit;
	logic [7:0]       res_port;
	logic [7:0]       res_byte;
	logic             res_last;
	status_t          res_status;
	logic             port_bad;
	logic [7:0]       port_diff;

	assign advance_s1 = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready  = !valid_s1 || advance_s1;
	assign take_in    = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_low_q   <= PORT_LOW_RST;
			port_limit_q <= PORT_LIMIT_RST;
			tag_offset_q <= PORT_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PORT_LOW:    port_low_q   <= cfg_data[7:0];
				CFG_PORT_LIMIT:  port_limit_q <= cfg_data[8:0];
				CFG_PORT_OFFSET: tag_offset_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= din.data_byte;
			eot_s1  <= din.end_of_transfer;
		end
	end

	assign port_diff = byte_s1 - tag_offset_q;
	assign port_bad  = (byte_s1 < port_low_q) || ({1'b0, byte_s1} >= port_limit_q);

	always_comb begin
		pos_d      = pos_q;
		cur_port_d = cur_port_q;
		rem_d      = rem_q;
		skip_d     = skip_q;
		emit       = 1'b0;
		res_port   = cur_port_q;
		res_byte   = 8'd0;
		res_last   = 1'b0;
		res_status = ST_PAYLOAD;
		if (!skip_q) begin
			if (pos_q == POS_W'(0)) begin
				rem_d = '0;
				if (port_bad) begin
					emit       = 1'b1;
					res_port   = port_diff;
					res_status = ST_PORT_ERR;
					skip_d     = 1'b1;
				end else begin
					cur_port_d = port_diff;
				end
			end else if (pos_q == POS_W'(1)) begin
				if (byte_s1 > 8'(MAX_PAYLOAD)) begin
					emit       = 1'b1;
					res_status = ST_LEN_ERR;
					skip_d     = 1'b1;
				end else begin
					rem_d = byte_s1[REM_W-1:0];
				end
			end else if (rem_q != '0) begin
				emit     = 1'b1;
				res_byte = byte_s1;
				res_last = (rem_q == REM_W'(1)) || (pos_q == POS_W'(RECORD_BYTES - 1));
				rem_d    = rem_q - REM_W'(1);
			end
			// wrap at the record end
			pos_d = (pos_q == POS_W'(RECORD_BYTES - 1)) ? '0 : pos_q + POS_W'(1);
		end
		if (eot_s1) begin
			pos_d  = '0;
			rem_d  = '0;
			skip_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			cur_port_q <= '0;
			rem_q      <= '0;
			skip_q     <= 1'b0;
		end else if (advance_s1) begin
			pos_q      <= pos_d;
			cur_port_q <= cur_port_d;
			rem_q      <= rem_d;
			skip_q     <= skip_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= emit;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			out_port_q   <= res_port;
			out_byte_q   <= res_byte;
			out_last_q   <= res_last;
			out_status_q <= res_status;
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.port         = out_port_q;
	assign dout.payload_byte = out_byte_q;
	assign dout.record_last  = out_last_q;
	assign dout.status       = out_status_q;

`ifndef ASSERT_OFF
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_PAYLOAD) |-> (out_byte_q == 8'd0 && !out_last_q))
		else $error("error result carries payload data");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && skip_q) |=> !out_valid_q)
		else $error("result emitted while skipping");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= REM_W'(MAX_PAYLOAD))
		else $error("remaining count above maximum payload");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s1) |=> (valid_s1 && $stable(byte_s1) && $stable(pos_q)))
		else $error("input stage lost a byte during stall");
`endif

endmodule

`default_nettype wire
